[design/circle_rectangle_proximity_macros.svh]
// ----------------------------------------------------------------------------
// circle_rectangle_proximity assertion macros
// concurrent checks on the rising clock edge, gated off during reset
// ----------------------------------------------------------------------------
`ifndef CIRCLE_RECTANGLE_PROXIMITY_MACROS_SVH
`define CIRCLE_RECTANGLE_PROXIMITY_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CRP_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("circle_rectangle_proximity: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define CRP_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("circle_rectangle_proximity: next-cycle check failed");

`endif

[design/crp_pkg.sv]
// ----------------------------------------------------------------------------
// crp_pkg
// word types of the circle / oriented rectangle proximity block
// ----------------------------------------------------------------------------
package crp_pkg;

  // one circle / rectangle pair, Q15.16 coordinates, Q1.14 heading
  typedef struct packed {
    logic signed [31:0] circle_x;
    logic signed [31:0] circle_y;
    logic        [30:0] circle_radius;
    logic signed [31:0] rect_x;
    logic signed [31:0] rect_y;
    logic signed [15:0] rect_cos;
    logic signed [15:0] rect_sin;
    logic        [30:0] rect_width;
    logic        [30:0] rect_height;
    logic               rect_first;
  } shape_word_t;

  // separation distance and the two closest points, Q15.16
  typedef struct packed {
    logic signed [31:0] distance;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic               degenerate;
  } prox_word_t;

endpackage

[design/crp_stream_if.sv]
// ----------------------------------------------------------------------------
// crp_stream_if
// valid / ready channel carrying one word of a given type
// ----------------------------------------------------------------------------
interface crp_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/circle_rectangle_proximity.sv]
// ----------------------------------------------------------------------------
// circle_rectangle_proximity
// signed distance and closest points between a circle and an oriented
// rectangle, fully pipelined
// ----------------------------------------------------------------------------
//
//   channel   role    word            contents
//   -------   -----   -------------   ------------------------------------
//   shapes    sink    shape_word_t    circle centre/radius, rectangle pose
//   result    source  prox_word_t     distance, two points, degenerate flag
//
// one pair enters per cycle unless a stalled result backs up every stage; the 32-step
// square root spans 8 stages of 4 steps, the 34-bit quotient dividers 9 stages of 4
// reset clears only the stage valid bits; payload registers are not reset
// a stall on result holds the last stage; earlier stages keep moving into
// empty slots, so bubbles close up and shapes stays ready while any is free
//
module circle_rectangle_proximity (
  input  logic          clk,
  input  logic          rst,
  crp_stream_if.sink    shapes,
  crp_stream_if.source  result
);
  import crp_pkg::*;

  // stage map
  localparam int S_DIFF   = 0;   // centre minus rectangle centre
  localparam int S_MUL1   = 1;   // rotation products into the local frame
  localparam int S_LOC    = 2;   // local coordinates, Q.17
  localparam int S_CLAMP  = 3;   // nearest boundary point, local frame
  localparam int S_MUL2   = 4;   // rotation products back to global
  localparam int S_GLOB   = 5;   // rectangle point, global Q.17
  localparam int S_ERR    = 6;   // rectangle point minus centre
  localparam int S_ABS    = 7;   // magnitudes and signs
  localparam int S_NORM   = 8;   // scale down below 2^31
  localparam int S_SQM    = 9;   // squares
  localparam int S_SQS    = 10;  // sum of squares
  localparam int ROOT_ITERS = 32;
  localparam int ROOT_PER = 4;
  localparam int ROOT_ST  = ROOT_ITERS / ROOT_PER;
  localparam int S_ROOT0  = 11;
  localparam int S_ROOTL  = S_ROOT0 + ROOT_ST - 1;
  localparam int S_LEN    = S_ROOTL + 1;  // rounded length, scaled back
  localparam int S_PMUL   = S_LEN + 1;    // |e| * 2r partial products
  localparam int S_NUM    = S_PMUL + 1;   // dividend and first remainder
  localparam int QW       = 34;           // quotient bits (q stays below 2^33)
  localparam int DIV_PER  = 4;
  localparam int DIV_ST   = (QW + DIV_PER - 1) / DIV_PER;
  localparam int S_DIV0   = S_NUM + 1;
  localparam int S_DIVL   = S_DIV0 + DIV_ST - 1;
  localparam int S_PT     = S_DIVL + 1;   // circle point
  localparam int S_OUT    = S_PT + 1;     // rounding, saturation, ordering
  localparam int NSTAGE   = S_OUT + 1;

  // widths
  localparam int DW    = 33;        // centre difference
  localparam int PW1   = DW + 16;   // cos * dx
  localparam int SW1   = PW1 + 1;
  localparam int LW    = 37;        // local coordinate
  localparam int PXW   = 38;        // clamped local point
  localparam int PW2   = PXW + 16;
  localparam int SW2   = PW2 + 1;
  localparam int GW    = 43;        // global rectangle point, Q.17
  localparam int EW    = 44;        // difference vector
  localparam int AW    = EW;        // magnitude
  localparam int NW    = 31;        // normalized magnitude
  localparam int SH_MAX = AW - NW;
  localparam int SHW   = 4;
  localparam int SQW   = 2 * NW;
  localparam int RW    = 33;        // rounded root
  localparam int LENW  = RW + SH_MAX;
  localparam int BW    = 32;        // twice the radius
  localparam int ALO   = AW / 2;
  localparam int MPW   = ALO + BW;
  localparam int NUMW  = AW + BW;
  localparam int REMW  = LENW + 1;
  localparam int P1W   = 36;
  localparam int DSW   = 48;
  localparam int LOC_SH = 13;
  localparam int GLB_SH = 14;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic        [30:0] rad;
    logic               swap;
  } keep_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } root_t;

  typedef struct packed {
    logic [REMW-1:0] rem;
    logic [QW-1:0]   num;
    logic [QW-1:0]   q;
  } div_t;

  // four steps of the digit-by-digit square root
  function automatic root_t root_step(input root_t s, input int base);
    logic [63:0] xx;
    logic [63:0] rr;
    logic [63:0] bv;
    logic [63:0] tr;
    root_t       o;
    xx = s.x;
    rr = s.r;
    for (int t = 0; t < ROOT_PER; t++) begin
      bv = 64'd1 << (62 - 2 * (base + t));
      tr = rr + bv;
      if (xx >= tr) begin
        xx = xx - tr;
        rr = (rr >> 1) + bv;
      end else begin
        rr = rr >> 1;
      end
    end
    o.x = xx;
    o.r = rr;
    return o;
  endfunction

  // four steps of restoring division
  function automatic div_t div_step(input div_t s, input logic [LENW-1:0] den,
                                    input int base);
    logic [REMW-1:0] rr;
    logic [QW-1:0]   nn;
    logic [QW-1:0]   qq;
    div_t            o;
    rr = s.rem;
    nn = s.num;
    qq = s.q;
    for (int t = 0; t < DIV_PER; t++) begin
      if (base + t < QW) begin
        rr = {rr[REMW-2:0], nn[QW-1]};
        nn = nn << 1;
        if (rr >= {1'b0, den}) begin
          rr = rr - {1'b0, den};
          qq = {qq[QW-2:0], 1'b1};
        end else begin
          qq = {qq[QW-2:0], 1'b0};
        end
      end
    end
    o.rem = rr;
    o.num = nn;
    o.q   = qq;
    return o;
  endfunction

  // halve with halves up, then clamp to 32-bit signed
  function automatic logic signed [31:0] round_sat(input logic signed [DSW-1:0] val);
    logic signed [DSW-1:0] t;
    t = (val + DSW'(1)) >>> 1;
    if (t > DSW'(32'sh7fffffff)) return 32'sh7fffffff;
    if (t < DSW'(32'sh80000000)) return 32'sh80000000;
    return 32'(t);
  endfunction

  // ---------------------------------------------------------------- control
  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] en;
  logic              in_acc;
  logic              out_acc;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || result.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign shapes.ready = en[0];
  assign result.valid = v[S_OUT];
  assign in_acc  = shapes.valid && shapes.ready;
  assign out_acc = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= shapes.valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // ------------------------------------------------------- carried fields
  keep_t keep [S_DIFF:S_PT];
  logic signed [GW-1:0] gx_p [S_GLOB:S_PT];
  logic signed [GW-1:0] gy_p [S_GLOB:S_PT];
  logic [AW-1:0] ax_p [S_ABS:S_LEN];
  logic [AW-1:0] ay_p [S_ABS:S_LEN];
  logic          sx_p [S_ABS:S_DIVL];
  logic          sy_p [S_ABS:S_DIVL];
  logic [SHW-1:0] sh_p [S_NORM:S_ROOTL];
  logic [LENW-1:0] len_p [S_LEN:S_DIVL-1];
  logic          deg_p [S_LEN:S_DIVL];
  logic signed [DSW-1:0] dist_p [S_PMUL:S_PT];

  for (genvar k = S_DIFF + 1; k <= S_PT; k++) begin : g_keep
    always_ff @(posedge clk) if (en[k]) keep[k] <= keep[k-1];
  end
  for (genvar k = S_GLOB + 1; k <= S_PT; k++) begin : g_gpt
    always_ff @(posedge clk) begin
      if (en[k]) begin
        gx_p[k] <= gx_p[k-1];
        gy_p[k] <= gy_p[k-1];
      end
    end
  end
  for (genvar k = S_ABS + 1; k <= S_LEN; k++) begin : g_mag
    always_ff @(posedge clk) begin
      if (en[k]) begin
        ax_p[k] <= ax_p[k-1];
        ay_p[k] <= ay_p[k-1];
      end
    end
  end
  for (genvar k = S_ABS + 1; k <= S_DIVL; k++) begin : g_sgn
    always_ff @(posedge clk) begin
      if (en[k]) begin
        sx_p[k] <= sx_p[k-1];
        sy_p[k] <= sy_p[k-1];
      end
    end
  end
  for (genvar k = S_NORM + 1; k <= S_ROOTL; k++) begin : g_sh
    always_ff @(posedge clk) if (en[k]) sh_p[k] <= sh_p[k-1];
  end
  for (genvar k = S_LEN + 1; k <= S_DIVL - 1; k++) begin : g_len
    always_ff @(posedge clk) if (en[k]) len_p[k] <= len_p[k-1];
  end
  for (genvar k = S_LEN + 1; k <= S_DIVL; k++) begin : g_deg
    always_ff @(posedge clk) if (en[k]) deg_p[k] <= deg_p[k-1];
  end
  for (genvar k = S_PMUL + 1; k <= S_PT; k++) begin : g_dist
    always_ff @(posedge clk) if (en[k]) dist_p[k] <= dist_p[k-1];
  end

  // ------------------------------------------------ into the local frame
  logic signed [DW-1:0]  dx0, dy0;
  logic signed [15:0]    co0, si0, co1, si1, co2, si2, co3, si3;
  logic signed [31:0]    rx0, ry0, rx1, ry1, rx2, ry2, rx3, ry3, rx4, ry4;
  logic        [30:0]    hw0, hh0, hw1, hh1, hw2, hh2;
  logic signed [PW1-1:0] m_cdx, m_sdy, m_cdy, m_sdx;
  logic signed [SW1-1:0] loc_x, loc_y;
  logic signed [LW-1:0]  lx2, ly2;

  always_ff @(posedge clk) begin
    if (en[S_DIFF]) begin
      dx0 <= DW'(shapes.data.circle_x) - DW'(shapes.data.rect_x);
      dy0 <= DW'(shapes.data.circle_y) - DW'(shapes.data.rect_y);
      co0 <= shapes.data.rect_cos;
      si0 <= shapes.data.rect_sin;
      rx0 <= shapes.data.rect_x;
      ry0 <= shapes.data.rect_y;
      hw0 <= shapes.data.rect_width;   // half width in Q.17 is the raw field
      hh0 <= shapes.data.rect_height;
      keep[S_DIFF] <= '{cx: shapes.data.circle_x, cy: shapes.data.circle_y,
                        rad: shapes.data.circle_radius, swap: shapes.data.rect_first};
    end
    if (en[S_MUL1]) begin
      m_cdx <= co0 * dx0;
      m_sdy <= si0 * dy0;
      m_cdy <= co0 * dy0;
      m_sdx <= si0 * dx0;
      co1 <= co0;  si1 <= si0;
      rx1 <= rx0;  ry1 <= ry0;
      hw1 <= hw0;  hh1 <= hh0;
    end
  end

  // Q1.14 times Q.16 is Q.30; down to Q.17 with halves up
  always_comb begin
    loc_x = SW1'(m_cdx) + SW1'(m_sdy) + (SW1'(1) <<< (LOC_SH - 1));
    loc_y = SW1'(m_cdy) - SW1'(m_sdx) + (SW1'(1) <<< (LOC_SH - 1));
  end

  always_ff @(posedge clk) begin
    if (en[S_LOC]) begin
      lx2 <= LW'(loc_x >>> LOC_SH);
      ly2 <= LW'(loc_y >>> LOC_SH);
      co2 <= co1;  si2 <= si1;
      rx2 <= rx1;  ry2 <= ry1;
      hw2 <= hw1;  hh2 <= hh1;
    end
  end

  // ------------------------------------------ nearest point on the boundary
  logic signed [PXW-1:0] hws, hhs, lxe, lye, abx, aby, bx, by, px_c, py_c;
  logic signed [PXW-1:0] px3, py3;
  logic                  inx, iny;

  always_comb begin
    hws = PXW'($signed({1'b0, hw2}));
    hhs = PXW'($signed({1'b0, hh2}));
    lxe = PXW'(lx2);
    lye = PXW'(ly2);
    inx = (lxe > -hws) && (lxe < hws);
    iny = (lye > -hhs) && (lye < hhs);
    abx = (lxe < 0) ? -lxe : lxe;
    aby = (lye < 0) ? -lye : lye;
    bx  = hws - abx;
    by  = hhs - aby;
    // strictly inside: snap to the closer pair of sides, ties to the sides at +-x
    if (inx && iny) begin
      if (bx <= by) inx = 1'b0;
      else          iny = 1'b0;
    end
    px_c = inx ? lxe : ((lxe < 0) ? -hws : hws);
    py_c = iny ? lye : ((lye < 0) ? -hhs : hhs);
  end

  logic signed [PW2-1:0] m_cpx, m_spy, m_spx, m_cpy;
  logic signed [SW2-1:0] glb_x, glb_y;

  always_ff @(posedge clk) begin
    if (en[S_CLAMP]) begin
      px3 <= px_c;
      py3 <= py_c;
      co3 <= co2;  si3 <= si2;
      rx3 <= rx2;  ry3 <= ry2;
    end
    if (en[S_MUL2]) begin
      m_cpx <= co3 * px3;
      m_spy <= si3 * py3;
      m_spx <= si3 * px3;
      m_cpy <= co3 * py3;
      rx4 <= rx3;  ry4 <= ry3;
    end
  end

  // back to global, Q.31 down to Q.17
  always_comb begin
    glb_x = SW2'(m_cpx) - SW2'(m_spy) + (SW2'(1) <<< (GLB_SH - 1));
    glb_y = SW2'(m_spx) + SW2'(m_cpy) + (SW2'(1) <<< (GLB_SH - 1));
  end

  logic signed [EW-1:0] ex6, ey6;

  always_ff @(posedge clk) begin
    if (en[S_GLOB]) begin
      gx_p[S_GLOB] <= GW'($signed({rx4, 1'b0})) + GW'(glb_x >>> GLB_SH);
      gy_p[S_GLOB] <= GW'($signed({ry4, 1'b0})) + GW'(glb_y >>> GLB_SH);
    end
    if (en[S_ERR]) begin
      ex6 <= EW'(gx_p[S_GLOB]) - EW'($signed({keep[S_GLOB].cx, 1'b0}));
      ey6 <= EW'(gy_p[S_GLOB]) - EW'($signed({keep[S_GLOB].cy, 1'b0}));
    end
    if (en[S_ABS]) begin
      ax_p[S_ABS] <= AW'((ex6 < 0) ? -ex6 : ex6);
      ay_p[S_ABS] <= AW'((ey6 < 0) ? -ey6 : ey6);
      sx_p[S_ABS] <= ex6 < 0;
      sy_p[S_ABS] <= ey6 < 0;
    end
  end

  // --------------------------------------------------------------- length
  logic [AW-1:0]  orv;
  logic [SHW-1:0] shv;
  logic [NW-1:0]  axs8, ays8;
  logic [SQW-1:0] sqx9, sqy9;
  logic [SQW:0]   sq10;

  // halve both components until each fits in 31 bits
  always_comb begin
    orv = ax_p[S_ABS] | ay_p[S_ABS];
    shv = '0;
    for (int i = 0; i < SH_MAX; i++) begin
      if (orv[NW + i]) shv = SHW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_NORM]) begin
      axs8 <= NW'(ax_p[S_ABS] >> shv);
      ays8 <= NW'(ay_p[S_ABS] >> shv);
      sh_p[S_NORM] <= shv;
    end
    if (en[S_SQM]) begin
      sqx9 <= axs8 * axs8;
      sqy9 <= ays8 * ays8;
    end
    if (en[S_SQS]) begin
      sq10 <= (SQW + 1)'(sqx9) + (SQW + 1)'(sqy9);
    end
  end

  root_t rt [S_ROOT0:S_ROOTL];

  always_ff @(posedge clk) begin
    if (en[S_ROOT0]) rt[S_ROOT0] <= root_step('{x: 64'(sq10), r: 64'd0}, 0);
  end
  for (genvar k = S_ROOT0 + 1; k <= S_ROOTL; k++) begin : g_root
    always_ff @(posedge clk) begin
      if (en[k]) rt[k] <= root_step(rt[k-1], (k - S_ROOT0) * ROOT_PER);
    end
  end

  // round to nearest: the remainder is s - r*r
  logic [RW-1:0] r_round;
  assign r_round = RW'(rt[S_ROOTL].r) + RW'(rt[S_ROOTL].x > rt[S_ROOTL].r);

  always_ff @(posedge clk) begin
    if (en[S_LEN]) begin
      len_p[S_LEN] <= LENW'(r_round) << sh_p[S_ROOTL];
      deg_p[S_LEN] <= r_round == '0;
    end
  end

  // ------------------------------------------------ radius step, |e|*2r/len
  logic [BW-1:0]   rad2;
  logic [MPW-1:0]  plx, phx, ply, phy;
  logic [LENW-1:0] len20;
  logic [NUMW-1:0] numx, numy;

  assign rad2 = {keep[S_LEN].rad, 1'b0};

  always_ff @(posedge clk) begin
    if (en[S_PMUL]) begin
      plx <= ax_p[S_LEN][ALO-1:0] * rad2;
      phx <= ax_p[S_LEN][AW-1:ALO] * rad2;
      ply <= ay_p[S_LEN][ALO-1:0] * rad2;
      phy <= ay_p[S_LEN][AW-1:ALO] * rad2;
      len20 <= len_p[S_LEN];
      dist_p[S_PMUL] <= DSW'(len_p[S_LEN]) - DSW'(rad2);
    end
  end

  // dividend with half the divisor added for rounding
  always_comb begin
    numx = (NUMW'(phx) << ALO) + NUMW'(plx) + NUMW'(len20 >> 1);
    numy = (NUMW'(phy) << ALO) + NUMW'(ply) + NUMW'(len20 >> 1);
  end

  div_t dvx [S_NUM:S_DIVL];
  div_t dvy [S_NUM:S_DIVL];

  // quotient is below 2^33, so the bits above QW start as the remainder
  always_ff @(posedge clk) begin
    if (en[S_NUM]) begin
      dvx[S_NUM] <= '{rem: REMW'(numx >> QW), num: numx[QW-1:0], q: '0};
      dvy[S_NUM] <= '{rem: REMW'(numy >> QW), num: numy[QW-1:0], q: '0};
    end
  end

  for (genvar k = S_DIV0; k <= S_DIVL; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[k]) begin
        dvx[k] <= div_step(dvx[k-1], len_p[k-1], (k - S_DIV0) * DIV_PER);
        dvy[k] <= div_step(dvy[k-1], len_p[k-1], (k - S_DIV0) * DIV_PER);
      end
    end
  end

  // ------------------------------------------------------- circle point
  logic signed [P1W-1:0] c2x, c2y, p1x31, p1y31;
  logic                  deg31;

  assign c2x = P1W'($signed({keep[S_DIVL].cx, 1'b0}));
  assign c2y = P1W'($signed({keep[S_DIVL].cy, 1'b0}));

  always_ff @(posedge clk) begin
    if (en[S_PT]) begin
      // centre on the boundary: no direction, the circle point is the centre
      if (deg_p[S_DIVL]) begin
        p1x31 <= c2x;
        p1y31 <= c2y;
      end else begin
        p1x31 <= c2x + (sx_p[S_DIVL] ? -P1W'(dvx[S_DIVL].q) : P1W'(dvx[S_DIVL].q));
        p1y31 <= c2y + (sy_p[S_DIVL] ? -P1W'(dvy[S_DIVL].q) : P1W'(dvy[S_DIVL].q));
      end
      deg31 <= deg_p[S_DIVL];
    end
  end

  // ----------------------------------------------------------- output word
  logic signed [31:0] cpx, cpy, rpx, rpy;

  always_comb begin
    cpx = round_sat(DSW'(p1x31));
    cpy = round_sat(DSW'(p1y31));
    rpx = round_sat(DSW'(gx_p[S_PT]));
    rpy = round_sat(DSW'(gy_p[S_PT]));
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      result.data <= '{
        distance:   round_sat(dist_p[S_PT]),
        first_x:    keep[S_PT].swap ? rpx : cpx,
        first_y:    keep[S_PT].swap ? rpy : cpy,
        second_x:   keep[S_PT].swap ? cpx : rpx,
        second_y:   keep[S_PT].swap ? cpy : rpy,
        degenerate: deg31
      };
    end
  end

  // ------------------------------------------------------------ assertions
`include "circle_rectangle_proximity_macros.svh"

  // occupancy tracks accepted minus delivered words
  `CRP_ASSERT_NEXT(a_occupancy, clk, rst, !rst, ($countones(v) == ($past($countones(v)) + $past(in_acc) - $past(out_acc))))
  // a full pipe with a stalled output takes nothing new
  `CRP_ASSERT_NOW(a_full_stall, clk, rst, ((&v) && !result.ready), !shapes.ready)
  // an empty first stage always takes a word
  `CRP_ASSERT_NOW(a_first_free, clk, rst, !v[S_DIFF], shapes.ready)

endmodule

[bench/crp_bench_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_bench_if
// bench-side note: the channel interface itself comes from the design folder
// ----------------------------------------------------------------------------
// the stream interface (crp_stream_if) is reused from the design as is;
// this file only holds small helpers shared by the bench
package crp_bench_pkg;
  import crp_pkg::*;

  // fixed-point helpers on 64-bit signed values
  function automatic longint rnd_sh(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// streams circle / rectangle pairs through the proximity block and checks
// every result word against a fixed-point predictor kept in the bench
// ----------------------------------------------------------------------------
module tb;
  import crp_pkg::*;
  import crp_bench_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  crp_stream_if #(.word_t(shape_word_t)) shapes_ch ();
  crp_stream_if #(.word_t(prox_word_t))  result_ch ();

  circle_rectangle_proximity dut (
    .clk    (clk),
    .rst    (rst),
    .shapes (shapes_ch.sink),
    .result (result_ch.source)
  );

  // longer than the pipe, so it covers the drain
  localparam int DRAIN_CYCLES = 60;

  prox_word_t expected_prox_q[$];
  int fail_count = 0;
  int pairs_sent = 0;
  int words_checked = 0;
  int degen_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // integer square root, rounded to nearest
  function automatic longint unsigned root_rounded(longint unsigned s);
    longint unsigned r, bitv, x;
    r = 0;
    bitv = 64'd1 << 62;
    x = s;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  // length of (x, y); halve both until they fit in 31 bits, scale back
  function automatic longint unsigned span_length(longint x, longint y);
    longint unsigned ax, ay;
    int sh;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    sh = 0;
    while ((ax | ay) >= (64'd1 << 31)) begin
      ax >>= 1;
      ay >>= 1;
      sh++;
    end
    return root_rounded(ax * ax + ay * ay) << sh;
  endfunction

  // round(a * b / c) with a wide intermediate, halves up
  function automatic longint unsigned scaled_quotient(longint unsigned a,
                                                      longint unsigned b,
                                                      longint unsigned c);
    logic [127:0] prod;
    prod = a * 128'(b);
    prod = prod + (c >> 1);
    return 64'(prod / c);
  endfunction

  // what the block should return for one pair
  function automatic prox_word_t predict_proximity(shape_word_t s);
    prox_word_t r;
    longint cx, cy, rad, rx, ry, co, si, hw, hh, dx, dy, lx, ly;
    longint px, py, gx, gy, ex, ey, p1x, p1y, sep, bx, by;
    longint unsigned len, qx, qy, lim;
    bit inx, iny, degen;
    cx = s.circle_x;
    cy = s.circle_y;
    rad = longint'(s.circle_radius);
    rx = s.rect_x;
    ry = s.rect_y;
    co = s.rect_cos;
    si = s.rect_sin;
    hw = longint'(s.rect_width);
    hh = longint'(s.rect_height);
    dx = cx - rx;
    dy = cy - ry;
    lx = rnd_sh(co * dx + si * dy, 13);
    ly = rnd_sh(co * dy - si * dx, 13);
    inx = (lx > -hw) && (lx < hw);
    iny = (ly > -hh) && (ly < hh);
    // strictly inside: snap to nearest side, ties to the sides at +-x
    if (inx && iny) begin
      bx = hw - ((lx < 0) ? -lx : lx);
      by = hh - ((ly < 0) ? -ly : ly);
      if (bx <= by) inx = 1'b0;
      else iny = 1'b0;
    end
    px = inx ? lx : ((lx < 0) ? -hw : hw);
    py = iny ? ly : ((ly < 0) ? -hh : hh);
    gx = 2 * rx + rnd_sh(co * px - si * py, 14);
    gy = 2 * ry + rnd_sh(si * px + co * py, 14);
    ex = gx - 2 * cx;
    ey = gy - 2 * cy;
    len = span_length(ex, ey);
    degen = (len == 0);
    if (degen) begin
      p1x = 2 * cx;
      p1y = 2 * cy;
    end else begin
      lim = 64'd1 << 40;
      qx = scaled_quotient((ex < 0) ? -ex : ex, 2 * rad, len);
      qy = scaled_quotient((ey < 0) ? -ey : ey, 2 * rad, len);
      if (qx > lim) qx = lim;
      if (qy > lim) qy = lim;
      p1x = 2 * cx + ((ex < 0) ? -longint'(qx) : longint'(qx));
      p1y = 2 * cy + ((ey < 0) ? -longint'(qy) : longint'(qy));
    end
    sep = rnd_sh(longint'(len) - 2 * rad, 1);
    r.distance = clamp32(sep);
    if (s.rect_first) begin
      r.first_x  = clamp32(rnd_sh(gx, 1));
      r.first_y  = clamp32(rnd_sh(gy, 1));
      r.second_x = clamp32(rnd_sh(p1x, 1));
      r.second_y = clamp32(rnd_sh(p1y, 1));
    end else begin
      r.first_x  = clamp32(rnd_sh(p1x, 1));
      r.first_y  = clamp32(rnd_sh(p1y, 1));
      r.second_x = clamp32(rnd_sh(gx, 1));
      r.second_y = clamp32(rnd_sh(gy, 1));
    end
    r.degenerate = degen;
    return r;
  endfunction

  // offer one pair, hold it until accepted, with a random gap first;
  // valid stays high on return so the next pair can follow directly
  task automatic send_pair(shape_word_t s);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      shapes_ch.valid <= 1'b0;
      @(posedge clk);
    end
    shapes_ch.valid <= 1'b1;
    shapes_ch.data  <= s;
    expected_prox_q.push_back(predict_proximity(s));
    pairs_sent++;
    @(posedge clk);
    while (!shapes_ch.ready) @(posedge clk);
  endtask

  // drop valid after the last pair of a burst
  task automatic release_input();
    shapes_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls on ready
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // checker: each accepted result word against the oldest expectation
  always @(posedge clk) begin
    prox_word_t want, got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (expected_prox_q.size() == 0) begin
        $display("%0t: result word with nothing expected: %p", $time, got);
        fail_count++;
      end else begin
        want = expected_prox_q.pop_front();
        words_checked++;
        if (got.degenerate) degen_seen++;
        if (got.distance !== want.distance)
          $display("%0t: distance expected %0d actual %0d", $time, want.distance, got.distance);
        if (got.first_x !== want.first_x)
          $display("%0t: first_x expected %0d actual %0d", $time, want.first_x, got.first_x);
        if (got.first_y !== want.first_y)
          $display("%0t: first_y expected %0d actual %0d", $time, want.first_y, got.first_y);
        if (got.second_x !== want.second_x)
          $display("%0t: second_x expected %0d actual %0d", $time, want.second_x, got.second_x);
        if (got.second_y !== want.second_y)
          $display("%0t: second_y expected %0d actual %0d", $time, want.second_y, got.second_y);
        if (got.degenerate !== want.degenerate)
          $display("%0t: degenerate expected %0b actual %0b", $time, want.degenerate,
                   got.degenerate);
        if (got !== want) fail_count++;
      end
    end
  end

  // random pair; mostly moderate coordinates, sometimes full-range noise
  function automatic shape_word_t random_pair();
    shape_word_t s;
    int mode;
    mode = $urandom_range(9);
    s.circle_x = $urandom();
    s.circle_y = $urandom();
    s.rect_x = $urandom();
    s.rect_y = $urandom();
    s.circle_radius = 31'($urandom());
    s.rect_width = 31'($urandom());
    s.rect_height = 31'($urandom());
    s.rect_first = 1'($urandom_range(1));
    if (mode < 7) begin
      // near geometry so inside / edge / corner cases all come up
      s.circle_x = $signed(s.rect_x) + $signed(32'($urandom_range(0, 32'h0080_0000)))
                   - 32'sh0040_0000;
      s.circle_y = $signed(s.rect_y) + $signed(32'($urandom_range(0, 32'h0080_0000)))
                   - 32'sh0040_0000;
      s.circle_radius = 31'($urandom_range(0, 32'h0020_0000));
      s.rect_width = 31'($urandom_range(0, 32'h0040_0000));
      s.rect_height = 31'($urandom_range(0, 32'h0040_0000));
    end
    if (mode < 8) begin
      s.rect_cos = 16'($urandom_range(0, 32768)) - 16'sd16384;
      s.rect_sin = 16'($urandom_range(0, 32768)) - 16'sd16384;
    end else begin
      // any 16-bit heading, no normalization
      s.rect_cos = 16'($urandom());
      s.rect_sin = 16'($urandom());
    end
    return s;
  endfunction

  function automatic shape_word_t axis_pair(int unsigned w, int unsigned h);
    shape_word_t s;
    s = '0;
    s.rect_cos = 16'sd16384;
    s.rect_width = 31'(w);
    s.rect_height = 31'(h);
    s.circle_radius = 31'h0001_0000;
    return s;
  endfunction

  // hold off until every expected word is back
  task automatic wait_drained();
    while (expected_prox_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    shape_word_t s;
    // centre at rectangle centre of a square: tie picks the sides at +-x
    s = axis_pair(31'h0002_0000, 31'h0002_0000);
    send_pair(s);
    s.rect_first = 1'b1;
    send_pair(s);
    // centre on the boundary: degenerate
    s = axis_pair(31'h0002_0000, 31'h0001_0000);
    s.circle_x = 32'sh0001_0000;
    send_pair(s);
    // zero-size rectangle at the centre: degenerate too
    s = axis_pair(0, 0);
    send_pair(s);
    // outside on a local axis, both signs
    s = axis_pair(31'h0002_0000, 31'h0002_0000);
    s.circle_x = 32'sh0005_0000;
    send_pair(s);
    s.circle_x = -32'sh0005_0000;
    send_pair(s);
    s.circle_x = 0;
    s.circle_y = 32'sh0005_0000;
    send_pair(s);
    // corner region
    s.circle_x = -32'sh0004_0000;
    s.circle_y = -32'sh0004_0000;
    send_pair(s);
    // field extremes
    s.circle_x = 32'sh7fff_ffff;
    s.circle_y = 32'sh8000_0000;
    s.rect_x = 32'sh8000_0000;
    s.rect_y = 32'sh7fff_ffff;
    s.circle_radius = 31'h7fff_ffff;
    s.rect_width = 31'h7fff_ffff;
    s.rect_height = 0;
    send_pair(s);
    s.rect_cos = -16'sd16384;
    s.rect_sin = 16'sd16384;
    s.rect_first = 1'b1;
    send_pair(s);
    s.rect_cos = 16'sh7fff;
    s.rect_sin = 16'sh8000;
    send_pair(s);
    s = '1;
    send_pair(s);
    s = '0;
    send_pair(s);
    // rotated by 90 degrees, inside near one edge
    s = axis_pair(31'h0004_0000, 31'h0002_0000);
    s.rect_cos = 0;
    s.rect_sin = 16'sd16384;
    s.circle_x = 32'sh0000_8000;
    send_pair(s);
    release_input();
    wait_drained();
  endtask

  task automatic test_random(int n, int sidle, int ridle);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    repeat (n) send_pair(random_pair());
  endtask

  initial begin
    shapes_ch.valid <= 1'b0;
    shapes_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(550, 10, 61);
    // sender pauses until all results are back
    release_input();
    wait_drained();
    test_random(550, 61, 10);
    test_random(500, 0, 0);
    release_input();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d pairs, %0d result words checked, %0d degenerate",
             pairs_sent, words_checked, degen_seen);
    if (fail_count == 0 && expected_prox_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[circle_rectangle_proximity.f]
+incdir+design
design/crp_pkg.sv
design/crp_stream_if.sv
design/circle_rectangle_proximity.sv
bench/crp_bench_if.sv
bench/tb.sv
